// ===== rtl/mdmsa_pkg.sv =====
package mdmsa_pkg;

    // Table geometry.
    localparam int MAX_SLOTS     = 64;
    localparam int INITIAL_SLOTS = 16;
    localparam int KEY_W         = 32;
    localparam int VALUE_W       = 32;
    localparam int SLOT_W        = $clog2(MAX_SLOTS);
    localparam int ADDR_W        = SLOT_W + 1;
    localparam int DEPTH         = 2 * MAX_SLOTS;
    localparam int CNT_W         = $clog2(MAX_SLOTS + 1);

    // Widths of the item fields.
    localparam int REQ_W     = 2;
    localparam int FIELD_W   = 32;
    localparam int OUT_CNT_W = 7;

    // Remainder unit: digits of DIGIT_W bits, one digit a cycle.
    localparam int DIGIT_W   = 4;
    localparam int MOD_STEPS = KEY_W / DIGIT_W;
    localparam int MOD_CNT_W = $clog2(MOD_STEPS);

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_GET    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_PUT    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd2;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd3;

    typedef logic [REQ_W-1:0]   req_type_t;
    typedef logic [FIELD_W-1:0] word_t;
    typedef logic [OUT_CNT_W-1:0] out_cnt_t;

endpackage

// ===== rtl/mdmsa_if.sv =====
interface mdmsa_req_if;
    import mdmsa_pkg::*;

    logic      valid;
    logic      ready;
    req_type_t req_type;
    word_t     key;
    word_t     value;

    modport source (output valid, output req_type, output key, output value, input ready);
    modport sink (input valid, input req_type, input key, input value, output ready);
endinterface

interface mdmsa_rsp_if;
    import mdmsa_pkg::*;

    logic     valid;
    logic     ready;
    logic     found;
    word_t    read_value;
    logic     status;
    out_cnt_t entry_count;
    out_cnt_t capacity;

    modport source (output valid, output found, output read_value, output status,
                    output entry_count, output capacity, input ready);
    modport sink (input valid, input found, input read_value, input status,
                  input entry_count, input capacity, output ready);
endinterface

// ===== rtl/mdmsa_ram.sv =====
module mdmsa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/modulo_direct_mapped_sparse_array.sv =====
// Sparse array of up to 64 entries: key k lives only in slot (k mod capacity) of the
// active bank. One request is handled at a time and gives one response item. A get,
// put or remove waits for the remainder unit, which takes the key apart four bits a
// cycle, and then for one key/value memory read; a clear needs no remainder. A put
// that collides starts a rebuild: for each candidate capacity from entry count + 1
// up to 64, the active bank is scanned slot by slot, each stored key costing a
// memory read and a remainder; the chosen capacity is then applied by a second scan
// that moves every entry into the other bank. The response register lets the next
// request be accepted while a response still waits to be taken.
module modulo_direct_mapped_sparse_array (
    input logic clk,
    input logic rst_n,
    mdmsa_req_if.sink   req,
    mdmsa_rsp_if.source rsp
);
    import mdmsa_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_HMOD  = 4'd1;
    localparam logic [3:0] S_HREAD = 4'd2;
    localparam logic [3:0] S_FNEW  = 4'd3;
    localparam logic [3:0] S_FSCAN = 4'd4;
    localparam logic [3:0] S_FRD   = 4'd5;
    localparam logic [3:0] S_FMOD  = 4'd6;
    localparam logic [3:0] S_RNEW  = 4'd7;
    localparam logic [3:0] S_RSCAN = 4'd8;
    localparam logic [3:0] S_RRD   = 4'd9;
    localparam logic [3:0] S_RMOD  = 4'd10;
    localparam logic [3:0] S_FIN   = 4'd11;

    logic [3:0]          state_reg, state_next;
    req_type_t           req_type_reg, req_type_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [VALUE_W-1:0]  value_reg, value_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [CNT_W-1:0]    n_reg, n_next;
    logic [CNT_W-1:0]    d_reg, d_next;
    logic                bank_reg, bank_next;
    logic [CNT_W-1:0]    modulus_reg, modulus_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [DEPTH-1:0]    occ_reg, occ_next;
    logic [MAX_SLOTS-1:0] probe_reg, probe_next;
    logic                found_reg, found_next;
    logic [VALUE_W-1:0]  rdval_reg, rdval_next;
    logic                status_reg, status_next;
    logic [KEY_W-1:0]    mov_key_reg, mov_key_next;
    logic [VALUE_W-1:0]  mov_val_reg, mov_val_next;

    logic                o_valid_reg, o_valid_next;
    logic                o_found_reg, o_found_next;
    word_t               o_val_reg, o_val_next;
    logic                o_status_reg, o_status_next;
    out_cnt_t            o_count_reg, o_count_next;
    out_cnt_t            o_cap_reg, o_cap_next;

    // Remainder unit.
    logic [KEY_W-1:0]     mod_a_reg, mod_a_next;
    logic [CNT_W-1:0]     mod_r_reg, mod_r_next;
    logic [CNT_W-1:0]     mod_n_reg, mod_n_next;
    logic [MOD_CNT_W-1:0] mod_cnt_reg, mod_cnt_next;
    logic                 mod_busy_reg, mod_busy_next;
    logic                 mod_done_reg, mod_done_next;
    logic                 mod_start;
    logic [KEY_W-1:0]     mod_op;
    logic [CNT_W-1:0]     mod_div;
    logic [SLOT_W-1:0]    rem;

    // Memory ports.
    logic                key_we, val_we;
    logic [ADDR_W-1:0]   waddr, raddr;
    logic [KEY_W-1:0]    wkey, rkey;
    logic [VALUE_W-1:0]  wval, rval;

    logic [ADDR_W-1:0]   hpos;
    logic                hit;
    logic [ADDR_W-1:0]   src_pos;

    mdmsa_ram #(.WIDTH(KEY_W), .DEPTH(DEPTH)) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (waddr),
        .wdata (wkey),
        .raddr (raddr),
        .rdata (rkey)
    );

    mdmsa_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_val_ram (
        .clk   (clk),
        .we    (val_we),
        .waddr (waddr),
        .wdata (wval),
        .raddr (raddr),
        .rdata (rval)
    );

    // Remainder of a key by a slot count, one digit per cycle.
    always_comb
    begin
        logic [CNT_W:0] t;
        logic [CNT_W-1:0] r;
        mod_a_next    = mod_a_reg;
        mod_r_next    = mod_r_reg;
        mod_n_next    = mod_n_reg;
        mod_cnt_next  = mod_cnt_reg;
        mod_busy_next = mod_busy_reg;
        mod_done_next = 1'b0;
        r = mod_r_reg;
        t = '0;
        if (mod_start)
        begin
            mod_a_next    = mod_op;
            mod_r_next    = '0;
            mod_n_next    = mod_div;
            mod_cnt_next  = '0;
            mod_busy_next = 1'b1;
        end
        else if (mod_busy_reg)
        begin
            for (int i = 0; i < DIGIT_W; i++)
            begin
                t = {r, mod_a_reg[KEY_W-1-i]};
                if (t >= {1'b0, mod_n_reg})
                begin
                    t = t - {1'b0, mod_n_reg};
                end
                r = t[CNT_W-1:0];
            end
            mod_r_next   = r;
            mod_a_next   = mod_a_reg << DIGIT_W;
            mod_cnt_next = mod_cnt_reg + 1'b1;
            if (mod_cnt_reg == MOD_CNT_W'(MOD_STEPS - 1))
            begin
                mod_busy_next = 1'b0;
                mod_done_next = 1'b1;
            end
        end
    end

    assign rem     = mod_r_reg[SLOT_W-1:0];
    assign hpos    = {bank_reg, slot_reg};
    assign hit     = occ_reg[hpos] && (rkey == key_reg);
    assign src_pos = {bank_reg, d_reg[SLOT_W-1:0]};

    // Request sequencer.
    always_comb
    begin
        state_next    = state_reg;
        req_type_next = req_type_reg;
        key_next      = key_reg;
        value_next    = value_reg;
        slot_next     = slot_reg;
        n_next        = n_reg;
        d_next        = d_reg;
        bank_next     = bank_reg;
        modulus_next  = modulus_reg;
        count_next    = count_reg;
        occ_next      = occ_reg;
        probe_next    = probe_reg;
        found_next    = found_reg;
        rdval_next    = rdval_reg;
        status_next   = status_reg;
        mov_key_next  = mov_key_reg;
        mov_val_next  = mov_val_reg;
        mod_start     = 1'b0;
        mod_op        = key_reg;
        mod_div       = n_reg;
        key_we        = 1'b0;
        val_we        = 1'b0;
        waddr         = '0;
        raddr         = '0;
        wkey          = key_reg;
        wval          = value_reg;

        // The response register empties when the item is taken.
        o_valid_next  = o_valid_reg && !rsp.ready;
        o_found_next  = o_found_reg;
        o_val_next    = o_val_reg;
        o_status_next = o_status_reg;
        o_count_next  = o_count_reg;
        o_cap_next    = o_cap_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    req_type_next = req.req_type;
                    key_next      = req.key[KEY_W-1:0];
                    value_next    = req.value[VALUE_W-1:0];
                    found_next    = 1'b0;
                    rdval_next    = '0;
                    status_next   = 1'b0;
                    if (req.req_type == REQ_CLEAR)
                    begin
                        occ_next   = '0;
                        count_next = '0;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        mod_start  = 1'b1;
                        mod_op     = req.key[KEY_W-1:0];
                        mod_div    = modulus_reg;
                        state_next = S_HMOD;
                    end
                end
            end

            // Home slot known: read its key and value.
            S_HMOD:
            begin
                if (mod_done_reg)
                begin
                    slot_next  = rem;
                    raddr      = {bank_reg, rem};
                    state_next = S_HREAD;
                end
            end

            S_HREAD:
            begin
                state_next = S_FIN;
                waddr      = hpos;
                case (req_type_reg)
                    REQ_GET:
                    begin
                        found_next = hit;
                        rdval_next = hit ? rval : '0;
                    end
                    REQ_PUT:
                    begin
                        if (hit)
                        begin
                            val_we = 1'b1;
                        end
                        else if (!occ_reg[hpos])
                        begin
                            key_we         = 1'b1;
                            val_we         = 1'b1;
                            occ_next[hpos] = 1'b1;
                            count_next     = count_reg + 1'b1;
                        end
                        else if ({1'b0, count_reg} >= (CNT_W + 1)'(MAX_SLOTS))
                        begin
                            status_next = 1'b1;
                        end
                        else
                        begin
                            n_next     = count_reg + 1'b1;
                            mod_start  = 1'b1;
                            mod_div    = count_reg + 1'b1;
                            state_next = S_FNEW;
                        end
                    end
                    REQ_REMOVE:
                    begin
                        if (hit)
                        begin
                            occ_next[hpos] = 1'b0;
                            count_next     = count_reg - 1'b1;
                        end
                    end
                    default:
                    begin
                        state_next = S_FIN;
                    end
                endcase
            end

            // Trial of one slot count: the new key claims its slot first.
            S_FNEW:
            begin
                if (mod_done_reg)
                begin
                    probe_next      = '0;
                    probe_next[rem] = 1'b1;
                    d_next          = '0;
                    state_next      = S_FSCAN;
                end
            end

            S_FSCAN:
            begin
                if (d_reg == CNT_W'(MAX_SLOTS))
                begin
                    // Every key fits: rebuild into the other bank.
                    occ_next[{~bank_reg, {SLOT_W{1'b0}}} +: MAX_SLOTS] = '0;
                    mod_start  = 1'b1;
                    state_next = S_RNEW;
                end
                else if (occ_reg[src_pos])
                begin
                    raddr      = src_pos;
                    state_next = S_FRD;
                end
                else
                begin
                    d_next = d_reg + 1'b1;
                end
            end

            S_FRD:
            begin
                mod_start  = 1'b1;
                mod_op     = rkey;
                state_next = S_FMOD;
            end

            S_FMOD:
            begin
                if (mod_done_reg)
                begin
                    if (probe_reg[rem])
                    begin
                        // Collision at this count: try the next one.
                        if (n_reg == CNT_W'(MAX_SLOTS))
                        begin
                            status_next = 1'b1;
                            state_next  = S_FIN;
                        end
                        else
                        begin
                            n_next     = n_reg + 1'b1;
                            mod_start  = 1'b1;
                            mod_div    = n_reg + 1'b1;
                            state_next = S_FNEW;
                        end
                    end
                    else
                    begin
                        probe_next[rem] = 1'b1;
                        d_next          = d_reg + 1'b1;
                        state_next      = S_FSCAN;
                    end
                end
            end

            // Place the new entry in the other bank.
            S_RNEW:
            begin
                if (mod_done_reg)
                begin
                    key_we                  = 1'b1;
                    val_we                  = 1'b1;
                    waddr                   = {~bank_reg, rem};
                    occ_next[{~bank_reg, rem}] = 1'b1;
                    d_next                  = '0;
                    state_next              = S_RSCAN;
                end
            end

            S_RSCAN:
            begin
                if (d_reg == CNT_W'(MAX_SLOTS))
                begin
                    bank_next    = ~bank_reg;
                    modulus_next = n_reg;
                    count_next   = count_reg + 1'b1;
                    state_next   = S_FIN;
                end
                else if (occ_reg[src_pos])
                begin
                    raddr      = src_pos;
                    state_next = S_RRD;
                end
                else
                begin
                    d_next = d_reg + 1'b1;
                end
            end

            S_RRD:
            begin
                mov_key_next = rkey;
                mov_val_next = rval;
                mod_start    = 1'b1;
                mod_op       = rkey;
                state_next   = S_RMOD;
            end

            // Move one entry to its slot under the new count.
            S_RMOD:
            begin
                if (mod_done_reg)
                begin
                    key_we                     = 1'b1;
                    val_we                     = 1'b1;
                    waddr                      = {~bank_reg, rem};
                    wkey                       = mov_key_reg;
                    wval                       = mov_val_reg;
                    occ_next[{~bank_reg, rem}] = 1'b1;
                    occ_next[src_pos]          = 1'b0;
                    d_next                     = d_reg + 1'b1;
                    state_next                 = S_RSCAN;
                end
            end

            // Hand the response item over once the register is free.
            S_FIN:
            begin
                if (!o_valid_reg || rsp.ready)
                begin
                    o_valid_next  = 1'b1;
                    o_found_next  = found_reg;
                    o_val_next    = FIELD_W'(rdval_reg);
                    o_status_next = status_reg;
                    o_count_next  = OUT_CNT_W'(count_reg);
                    o_cap_next    = OUT_CNT_W'(modulus_reg);
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            bank_reg     <= 1'b0;
            modulus_reg  <= CNT_W'(INITIAL_SLOTS);
            count_reg    <= '0;
            occ_reg      <= '0;
            o_valid_reg  <= 1'b0;
            mod_busy_reg <= 1'b0;
            mod_done_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            bank_reg     <= bank_next;
            modulus_reg  <= modulus_next;
            count_reg    <= count_next;
            occ_reg      <= occ_next;
            o_valid_reg  <= o_valid_next;
            mod_busy_reg <= mod_busy_next;
            mod_done_reg <= mod_done_next;
        end
    end

    // Payload and working registers.
    always_ff @(posedge clk)
    begin
        req_type_reg <= req_type_next;
        key_reg      <= key_next;
        value_reg    <= value_next;
        slot_reg     <= slot_next;
        n_reg        <= n_next;
        d_reg        <= d_next;
        probe_reg    <= probe_next;
        found_reg    <= found_next;
        rdval_reg    <= rdval_next;
        status_reg   <= status_next;
        mov_key_reg  <= mov_key_next;
        mov_val_reg  <= mov_val_next;
        o_found_reg  <= o_found_next;
        o_val_reg    <= o_val_next;
        o_status_reg <= o_status_next;
        o_count_reg  <= o_count_next;
        o_cap_reg    <= o_cap_next;
        mod_a_reg    <= mod_a_next;
        mod_r_reg    <= mod_r_next;
        mod_n_reg    <= mod_n_next;
        mod_cnt_reg  <= mod_cnt_next;
    end

    assign req.ready       = (state_reg == S_IDLE);
    assign rsp.valid       = o_valid_reg;
    assign rsp.found       = o_found_reg;
    assign rsp.read_value  = o_val_reg;
    assign rsp.status      = o_status_reg;
    assign rsp.entry_count = o_count_reg;
    assign rsp.capacity    = o_cap_reg;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import mdmsa_pkg::*;

    localparam int CYCLE_LIMIT = 40_000_000;
    localparam int NUM_RANDOM  = 1900;

    typedef struct packed {
        logic      drain;
        req_type_t op;
        word_t     key;
        word_t     value;
    } request_t;

    typedef struct packed {
        logic     found;
        word_t    read_value;
        logic     status;
        out_cnt_t entry_count;
        out_cnt_t capacity;
    } answer_t;

    logic clk;
    logic rst_n;

    mdmsa_req_if req ();
    mdmsa_rsp_if rsp ();

    modulo_direct_mapped_sparse_array dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    // Clock: 8 ns period.
    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    request_t pending_reqs[$];
    answer_t  expected_answers[$];
    int       accepted_count;
    int       cycle_count;
    int       error_count;
    int       send_idle_pct;
    int       recv_stall_pct;

    // Own copy of the table: two banks, modulus and entry count.
    word_t       tbl_key [DEPTH];
    word_t       tbl_val [DEPTH];
    logic        tbl_used[DEPTH];
    logic        tbl_bank;
    int unsigned tbl_mod;
    int unsigned tbl_count;

    // True when all stored keys and the new key fall in distinct slots mod n.
    function automatic logic keys_distinct(int unsigned n, word_t new_key);
        logic        taken[MAX_SLOTS];
        int unsigned base;
        int unsigned s;
        base = tbl_bank ? MAX_SLOTS : 0;
        for (int i = 0; i < MAX_SLOTS; i++)
            taken[i] = 1'b0;
        taken[new_key % n] = 1'b1;
        for (int d = 0; d < MAX_SLOTS; d++)
        begin
            if (tbl_used[base + d])
            begin
                s = tbl_key[base + d] % n;
                if (taken[s])
                    return 1'b0;
                taken[s] = 1'b1;
            end
        end
        return 1'b1;
    endfunction

    // Moves every entry and the new one into the other bank at modulus n.
    function automatic void relocate(int unsigned n, word_t new_key, word_t new_val);
        int unsigned src;
        int unsigned dst;
        int unsigned s;
        src = tbl_bank ? MAX_SLOTS : 0;
        dst = tbl_bank ? 0 : MAX_SLOTS;
        for (int d = 0; d < MAX_SLOTS; d++)
            tbl_used[dst + d] = 1'b0;
        s = new_key % n;
        tbl_key[dst + s]  = new_key;
        tbl_val[dst + s]  = new_val;
        tbl_used[dst + s] = 1'b1;
        for (int d = 0; d < MAX_SLOTS; d++)
        begin
            if (tbl_used[src + d])
            begin
                s = tbl_key[src + d] % n;
                tbl_key[dst + s]  = tbl_key[src + d];
                tbl_val[dst + s]  = tbl_val[src + d];
                tbl_used[dst + s] = 1'b1;
                tbl_used[src + d] = 1'b0;
            end
        end
        tbl_bank  = ~tbl_bank;
        tbl_mod   = n;
        tbl_count = tbl_count + 1;
    endfunction

    // Applies one request to the table copy and gives the answer it should produce.
    function automatic answer_t apply_request(req_type_t op, word_t key, word_t value);
        answer_t     a;
        int unsigned pos;
        logic        hit;
        logic        placed;
        a   = '0;
        pos = (tbl_bank ? MAX_SLOTS : 0) + (key % tbl_mod);
        hit = tbl_used[pos] && (tbl_key[pos] == key);
        case (op)
            REQ_GET:
            begin
                if (hit)
                begin
                    a.found      = 1'b1;
                    a.read_value = tbl_val[pos];
                end
            end
            REQ_PUT:
            begin
                if (hit)
                    tbl_val[pos] = value;
                else if (!tbl_used[pos])
                begin
                    tbl_key[pos]  = key;
                    tbl_val[pos]  = value;
                    tbl_used[pos] = 1'b1;
                    tbl_count     = tbl_count + 1;
                end
                else
                begin
                    placed = 1'b0;
                    for (int unsigned n = tbl_count + 1; n <= MAX_SLOTS && !placed; n++)
                    begin
                        if (keys_distinct(n, key))
                        begin
                            relocate(n, key, value);
                            placed = 1'b1;
                        end
                    end
                    a.status = !placed;
                end
            end
            REQ_REMOVE:
            begin
                if (hit)
                begin
                    tbl_used[pos] = 1'b0;
                    tbl_count     = tbl_count - 1;
                end
            end
            default:
            begin
                for (int d = 0; d < DEPTH; d++)
                    tbl_used[d] = 1'b0;
                tbl_count = 0;
            end
        endcase
        a.entry_count = out_cnt_t'(tbl_count);
        a.capacity    = out_cnt_t'(tbl_mod);
        return a;
    endfunction

    // Idling profile follows the number of items accepted so far.
    always_comb
    begin
        if (accepted_count < 400)
        begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
        end
        else if (accepted_count < 900)
        begin
            send_idle_pct  = 57;
            recv_stall_pct = 0;
        end
        else if (accepted_count < 1400)
        begin
            send_idle_pct  = 0;
            recv_stall_pct = 57;
        end
        else if (accepted_count < 1750)
        begin
            send_idle_pct  = 7;
            recv_stall_pct = 7;
        end
        else
        begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
        end
    end

    // Request driver: predicts on acceptance, then offers the next item.
    always @(posedge clk or negedge rst_n)
    begin
        request_t nxt;
        if (!rst_n)
        begin
            req.valid      <= 1'b0;
            req.req_type   <= REQ_GET;
            req.key        <= '0;
            req.value      <= '0;
            accepted_count <= 0;
        end
        else
        begin
            if (req.valid && req.ready)
            begin
                expected_answers.push_back(apply_request(req.req_type, req.key, req.value));
                accepted_count <= accepted_count + 1;
            end
            if (!req.valid || req.ready)
            begin
                if (pending_reqs.size() > 0 && pending_reqs[0].drain
                    && expected_answers.size() == 0 && !req.valid)
                    void'(pending_reqs.pop_front());
                if (pending_reqs.size() > 0 && !pending_reqs[0].drain
                    && $urandom_range(99) >= send_idle_pct)
                begin
                    nxt = pending_reqs.pop_front();
                    req.valid    <= 1'b1;
                    req.req_type <= nxt.op;
                    req.key      <= nxt.key;
                    req.value    <= nxt.value;
                end
                else
                    req.valid <= 1'b0;
            end
        end
    end

    // Response monitor: compares each item with the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin
        answer_t want;
        if (!rst_n)
            rsp.ready <= 1'b0;
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (expected_answers.size() == 0)
                begin
                    $display("%0t: unexpected response item found=%0d value=%h", $time,
                             rsp.found, rsp.read_value);
                    error_count++;
                end
                else
                begin
                    want = expected_answers.pop_front();
                    if (rsp.found !== want.found)
                    begin
                        $display("%0t: found expected %0d actual %0d", $time,
                                 want.found, rsp.found);
                        error_count++;
                    end
                    if (rsp.read_value !== want.read_value)
                    begin
                        $display("%0t: read_value expected %h actual %h", $time,
                                 want.read_value, rsp.read_value);
                        error_count++;
                    end
                    if (rsp.status !== want.status)
                    begin
                        $display("%0t: status expected %0d actual %0d", $time,
                                 want.status, rsp.status);
                        error_count++;
                    end
                    if (rsp.entry_count !== want.entry_count)
                    begin
                        $display("%0t: entry_count expected %0d actual %0d", $time,
                                 want.entry_count, rsp.entry_count);
                        error_count++;
                    end
                    if (rsp.capacity !== want.capacity)
                    begin
                        $display("%0t: capacity expected %0d actual %0d", $time,
                                 want.capacity, rsp.capacity);
                        error_count++;
                    end
                end
            end
            rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic queue_req(req_type_t op, word_t key, word_t value);
        pending_reqs.push_back('{drain: 1'b0, op: op, key: key, value: value});
    endtask

    // Stimulus and end of run.
    initial
    begin
        word_t key_pool[$];
        int    roll;
        word_t k;
        error_count    = 0;
        cycle_count    = 0;
        tbl_bank       = 1'b0;
        tbl_mod        = INITIAL_SLOTS;
        tbl_count      = 0;
        for (int d = 0; d < DEPTH; d++)
        begin
            tbl_used[d] = 1'b0;
            tbl_key[d]  = '0;
            tbl_val[d]  = '0;
        end
        rst_n = 1'b0;

        // Directed: misses on an empty table, extremes, replacement and removal.
        queue_req(REQ_GET, 32'h0, 32'h0);
        queue_req(REQ_REMOVE, 32'd5, 32'h0);
        queue_req(REQ_PUT, 32'h0, 32'hFFFF_FFFF);
        queue_req(REQ_PUT, 32'hFFFF_FFFF, 32'h0);
        queue_req(REQ_GET, 32'hFFFF_FFFF, 32'h0);
        queue_req(REQ_GET, 32'h0, 32'h0);
        queue_req(REQ_PUT, 32'h0, 32'hA5A5_5A5A);
        queue_req(REQ_GET, 32'h0, 32'h0);
        queue_req(REQ_GET, 32'h10, 32'h0);
        queue_req(REQ_REMOVE, 32'h0, 32'h0);
        queue_req(REQ_GET, 32'h0, 32'h0);
        queue_req(REQ_CLEAR, 32'h0, 32'h0);
        queue_req(REQ_GET, 32'hFFFF_FFFF, 32'h0);

        // Fill every slot so that the next colliding put is refused as full.
        for (int i = 0; i < MAX_SLOTS; i++)
            queue_req(REQ_PUT, word_t'(i), $urandom);
        queue_req(REQ_PUT, word_t'(MAX_SLOTS), 32'h1234_5678);
        queue_req(REQ_GET, 32'd63, 32'h0);

        // A collision at the full modulus after a clear shrinks the table.
        queue_req(REQ_CLEAR, 32'h0, 32'h0);
        queue_req(REQ_PUT, 32'd0, 32'd1);
        queue_req(REQ_PUT, word_t'(MAX_SLOTS), 32'd2);
        queue_req(REQ_GET, word_t'(MAX_SLOTS), 32'h0);
        queue_req(REQ_CLEAR, 32'h0, 32'h0);

        // Random: requests mostly on a small pool of keys so that hits and
        // collisions are common; the pool is refreshed now and then.
        for (int i = 0; i < NUM_RANDOM; i++)
        begin
            if (key_pool.size() == 0 || $urandom_range(99) < 2)
            begin
                key_pool.delete();
                roll = $urandom_range(20, 4);
                for (int j = 0; j < roll; j++)
                    key_pool.push_back($urandom_range(2) == 0 ? $urandom_range(200) : $urandom);
            end
            if (i == 700 || i == 1500)
                pending_reqs.push_back('{drain: 1'b1, op: REQ_GET, key: '0, value: '0});
            k = ($urandom_range(99) < 10) ? $urandom : key_pool[$urandom_range(key_pool.size() - 1)];
            roll = $urandom_range(99);
            if (roll < 35)
                queue_req(REQ_GET, k, $urandom);
            else if (roll < 77)
                queue_req(REQ_PUT, k, $urandom);
            else if (roll < 96)
                queue_req(REQ_REMOVE, k, $urandom);
            else
                queue_req(REQ_CLEAR, k, $urandom);
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        wait (pending_reqs.size() == 0);
        @(posedge clk);
        while (req.valid || expected_answers.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
